### hw/rtl/caac_pkg.sv
package caac_pkg;

  localparam int unsigned GenW   = 24;
  localparam int unsigned AliasW = 12;

  localparam logic [GenW-1:0] GenAddLo = 24'h7A4BA9;
  localparam logic [GenW-1:0] GenAddHi = 24'h1B0CA3;

  localparam logic [15:0] ConfirmWaitReset = 16'd500;

  // request types
  localparam logic [1:0] REQ_POLL   = 2'd0;
  localparam logic [1:0] REQ_RX     = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;

  // received frame kinds
  localparam logic [1:0] RK_CHECK   = 2'd0;
  localparam logic [1:0] RK_VERIFY  = 2'd2;

  // transmitted frame kinds
  localparam logic [1:0] FK_CHECK    = 2'd0;
  localparam logic [1:0] FK_RESERVE  = 2'd1;
  localparam logic [1:0] FK_INIT     = 2'd2;
  localparam logic [1:0] FK_VERIFIED = 2'd3;

  // configuration register indexes
  localparam logic CFG_NODE_ID      = 1'b0;
  localparam logic CFG_CONFIRM_WAIT = 1'b1;

  typedef enum logic [3:0] {
    PH_CHECK0      = 4'd0,
    PH_CHECK1      = 4'd1,
    PH_CHECK2      = 4'd2,
    PH_CHECK3      = 4'd3,
    PH_CHECK4      = 4'd4,
    PH_CHECK5      = 4'd5,
    PH_WAIT_BEGIN  = 4'd6,
    PH_WAITING     = 4'd7,
    PH_SEND_INIT   = 4'd8,
    PH_INITIALIZED = 4'd9,
    PH_NOT_STARTED = 4'd10
  } phase_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic        tx_ready;
    logic [1:0]  rx_kind;
    logic [11:0] rx_source_alias;
    logic [47:0] rx_node_id;
  } caac_req_t;

  typedef struct packed {
    logic        frame_valid;
    logic [1:0]  frame_kind;
    logic [11:0] frame_alias;
    logic [2:0]  check_index;
    logic [7:0]  check_id_byte;
    logic        link_ready;
  } caac_rsp_t;

  function automatic logic [AliasW-1:0] alias_of(input logic [GenW-1:0] hi,
                                                 input logic [GenW-1:0] lo);
    alias_of = hi[11:0] ^ lo[11:0] ^ hi[23:12] ^ lo[23:12];
  endfunction

endpackage

### hw/rtl/can_alias_allocation_controller_unit.sv
// CAN link alias allocation controller.
// Requests arrive on in_valid/in_ready with a caac_req_t payload: a poll
// step, a received frame or a start. Every accepted request yields exactly
// one response on out_valid/out_ready (caac_rsp_t), which tells whether a
// frame is to be sent, its kind, the current alias and the link status.
// The response is registered at the edge that accepts the request.
// Throughput is one request per cycle while the receiver does not stall; all decode,
// the 48-bit generator step and the wait compare sit between the request
// handshake and the response register.
// When the receiver stalls, the response is held and a new request is
// taken only in a cycle where the held response leaves, so in_ready
// follows out_ready while a response is pending.
// Configuration (cfg_we, cfg_index, cfg_data) writes node_id (index 0)
// and confirm_wait_ms (index 1); write only while no request is pending.
// Reset (rst, synchronous) clears the generator, sets the claim to not
// started, node_id to 0 and confirm_wait_ms to 500, and empties the
// response register.
module can_alias_allocation_controller_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  caac_pkg::caac_req_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output caac_pkg::caac_rsp_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [47:0]         cfg_data
);
  import caac_pkg::*;

  logic [47:0]     node_id;
  logic [15:0]     confirm_wait_ms;
  logic [GenW-1:0] gen_high, gen_high_next;
  logic [GenW-1:0] gen_low, gen_low_next;
  phase_t          phase, phase_next;
  logic [31:0]     wait_start, wait_start_next;
  caac_rsp_t       rsp_next;

  logic            in_fire;
  logic            do_step;
  logic [GenW-1:0] seed_high, seed_low;
  logic [GenW+1:0] sum_lo;
  logic [GenW-1:0] sum_hi;
  logic [11:0]     alias_cur;
  logic            alias_hit;
  logic            verify_hit;
  logic            wait_done;
  logic [31:0]     elapsed;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign alias_cur  = alias_of(gen_high, gen_low);
  assign alias_hit  = (in_data.rx_source_alias == alias_cur);
  assign verify_hit = (in_data.rx_kind == RK_VERIFY) && (in_data.rx_node_id == node_id);
  assign elapsed    = in_data.now_ms - wait_start;
  assign wait_done  = elapsed > {16'd0, confirm_wait_ms};

  // generator step on the seed, or on the current value
  always_comb begin
    if (in_data.req_type == REQ_START) begin
      seed_high = node_id[47:24];
      seed_low  = node_id[23:0];
    end else begin
      seed_high = gen_high;
      seed_low  = gen_low;
    end
    sum_lo = {2'b00, seed_low} + {2'b00, seed_low[14:0], 9'd0} + {2'b00, GenAddLo};
    sum_hi = seed_high + {seed_high[14:0], seed_low[23:15]} + GenAddHi
             + {22'd0, sum_lo[GenW+1:GenW]};
  end

  // next state
  always_comb begin
    phase_next      = phase;
    wait_start_next = wait_start;
    do_step         = 1'b0;
    case (in_data.req_type)
      REQ_START: begin
        do_step    = 1'b1;
        phase_next = PH_CHECK0;
      end
      REQ_POLL: begin
        case (phase)
          PH_CHECK0, PH_CHECK1, PH_CHECK2, PH_CHECK3, PH_CHECK4, PH_CHECK5: begin
            if (in_data.tx_ready) phase_next = phase_t'(phase + 4'd1);
          end
          PH_WAIT_BEGIN: begin
            wait_start_next = in_data.now_ms;
            phase_next      = PH_WAITING;
          end
          PH_WAITING: begin
            if (wait_done && in_data.tx_ready) phase_next = PH_SEND_INIT;
          end
          PH_SEND_INIT: begin
            if (in_data.tx_ready) phase_next = PH_INITIALIZED;
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
      REQ_RX: begin
        if (phase != PH_NOT_STARTED && alias_hit && in_data.rx_kind != RK_CHECK) begin
          do_step    = 1'b1;
          phase_next = PH_CHECK0;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
    if (do_step) begin
      gen_high_next = sum_hi;
      gen_low_next  = sum_lo[GenW-1:0];
    end else begin
      gen_high_next = gen_high;
      gen_low_next  = gen_low;
    end
  end

  // response
  always_comb begin
    rsp_next             = '0;
    rsp_next.frame_alias = alias_of(gen_high_next, gen_low_next);
    rsp_next.link_ready  = (phase_next == PH_INITIALIZED);
    case (in_data.req_type)
      REQ_POLL: begin
        case (phase)
          PH_CHECK0, PH_CHECK1, PH_CHECK2, PH_CHECK3, PH_CHECK4, PH_CHECK5: begin
            if (in_data.tx_ready) begin
              rsp_next.frame_valid = 1'b1;
              rsp_next.frame_kind  = FK_CHECK;
              rsp_next.check_index = phase[2:0];
              case (phase)
                PH_CHECK0: rsp_next.check_id_byte = node_id[47:40];
                PH_CHECK1: rsp_next.check_id_byte = node_id[39:32];
                PH_CHECK2: rsp_next.check_id_byte = node_id[31:24];
                PH_CHECK3: rsp_next.check_id_byte = node_id[23:16];
                PH_CHECK4: rsp_next.check_id_byte = node_id[15:8];
                default:   rsp_next.check_id_byte = node_id[7:0];
              endcase
            end
          end
          PH_WAITING: begin
            if (wait_done && in_data.tx_ready) begin
              rsp_next.frame_valid = 1'b1;
              rsp_next.frame_kind  = FK_RESERVE;
            end
          end
          PH_SEND_INIT: begin
            if (in_data.tx_ready) begin
              rsp_next.frame_valid = 1'b1;
              rsp_next.frame_kind  = FK_INIT;
            end
          end
          default: begin
            rsp_next.frame_valid = 1'b0;
          end
        endcase
      end
      REQ_RX: begin
        if (phase != PH_NOT_STARTED) begin
          if (verify_hit) begin
            rsp_next.frame_valid = 1'b1;
            rsp_next.frame_kind  = FK_VERIFIED;
          end else if (alias_hit && in_data.rx_kind == RK_CHECK) begin
            rsp_next.frame_valid = 1'b1;
            rsp_next.frame_kind  = FK_RESERVE;
          end
        end
      end
      default: begin
        rsp_next.frame_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id         <= '0;
      confirm_wait_ms <= ConfirmWaitReset;
      gen_high        <= '0;
      gen_low         <= '0;
      phase           <= PH_NOT_STARTED;
      wait_start      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_ID:      node_id <= cfg_data;
          CFG_CONFIRM_WAIT: confirm_wait_ms <= cfg_data[15:0];
          default:          node_id <= node_id;
        endcase
      end
      if (in_fire) begin
        gen_high   <= gen_high_next;
        gen_low    <= gen_low_next;
        phase      <= phase_next;
        wait_start <= wait_start_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_data <= rsp_next;
  end

`ifndef SYNTHESIS
  a_start_goes_to_check0: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.req_type == REQ_START |=> phase == PH_CHECK0)
    else $error("start did not restart the claim");

  a_wait_begin_records: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.req_type == REQ_POLL && phase == PH_WAIT_BEGIN
    |=> phase == PH_WAITING && wait_start == $past(in_data.now_ms))
    else $error("wait start not recorded");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.frame_valid
    |-> out_data.frame_kind == FK_CHECK && out_data.check_index == 3'd0
        && out_data.check_id_byte == 8'd0)
    else $error("fields set without a frame");

  a_check_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.check_index <= 3'd5)
    else $error("check index out of range");

  a_no_check_when_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.link_ready && out_data.frame_valid
    |-> out_data.frame_kind != FK_CHECK)
    else $error("check frame after link ready");

  a_alias_matches_gen: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_data.frame_alias == alias_of(gen_high, gen_low))
    else $error("response alias differs from generator");
`endif

endmodule

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import caac_pkg::*;

  // received kinds and request type the package leaves unnamed
  localparam logic [1:0] RK_RESERVE = 2'd1;
  localparam logic [1:0] RK_OTHER   = 2'd3;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  caac_req_t in_data;
  logic      out_valid;
  logic      out_ready;
  caac_rsp_t out_data;
  logic      cfg_we;
  logic      cfg_index;
  logic [47:0] cfg_data;

  // predictor state
  logic [47:0] m_node_id;
  logic [15:0] m_wait_ms;
  logic [23:0] m_gen_hi;
  logic [23:0] m_gen_lo;
  phase_t      m_phase;
  logic [31:0] m_wait_start;

  caac_rsp_t   expected_frames[$];
  caac_rsp_t   want_rsp;
  int unsigned errors;
  int unsigned sent;
  int unsigned cycles;
  int unsigned hold_req;
  bit          calm;

  can_alias_allocation_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic logic [11:0] model_alias();
    logic [23:0] x;
    x = m_gen_hi ^ m_gen_lo;
    return x[11:0] ^ x[23:12];
  endfunction

  // v + v*2^9 + constant, mod 2^48
  function automatic void step_generator();
    logic [47:0] v;
    v = {m_gen_hi, m_gen_lo};
    v = v + (v << 9) + {GenAddHi, GenAddLo};
    {m_gen_hi, m_gen_lo} = v;
  endfunction

  function automatic void restart_claim();
    step_generator();
    m_phase = PH_CHECK0;
  endfunction

  function automatic caac_rsp_t advance_claim(input caac_req_t r);
    caac_rsp_t   o;
    logic [2:0]  byte_pos;
    logic [31:0] elapsed;
    o = '0;
    case (r.req_type)
      REQ_START: begin
        {m_gen_hi, m_gen_lo} = m_node_id;
        restart_claim();
      end
      REQ_POLL: begin
        if (m_phase <= PH_CHECK5) begin
          if (r.tx_ready) begin
            byte_pos = 3'd5 - m_phase[2:0];
            o.frame_valid = 1'b1;
            o.frame_kind = FK_CHECK;
            o.check_index = m_phase[2:0];
            o.check_id_byte = m_node_id[8*byte_pos +: 8];
            m_phase = phase_t'(m_phase + 4'd1);
          end
        end else if (m_phase == PH_WAIT_BEGIN) begin
          m_wait_start = r.now_ms;
          m_phase = PH_WAITING;
        end else if (m_phase == PH_WAITING) begin
          elapsed = r.now_ms - m_wait_start;
          if (elapsed > {16'd0, m_wait_ms} && r.tx_ready) begin
            o.frame_valid = 1'b1;
            o.frame_kind = FK_RESERVE;
            m_phase = PH_SEND_INIT;
          end
        end else if (m_phase == PH_SEND_INIT) begin
          if (r.tx_ready) begin
            o.frame_valid = 1'b1;
            o.frame_kind = FK_INIT;
            m_phase = PH_INITIALIZED;
          end
        end
      end
      REQ_RX: begin
        if (m_phase != PH_NOT_STARTED) begin
          if (r.rx_source_alias == model_alias()) begin
            if (r.rx_kind == RK_CHECK) begin
              o.frame_valid = 1'b1;
              o.frame_kind = FK_RESERVE;
            end else begin
              restart_claim();
            end
          end
          if (r.rx_kind == RK_VERIFY && r.rx_node_id == m_node_id) begin
            o.frame_valid = 1'b1;
            o.frame_kind = FK_VERIFIED;
          end
        end
      end
      default: ;
    endcase
    o.frame_alias = model_alias();
    o.link_ready = (m_phase == PH_INITIALIZED);
    return o;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: response %h with nothing expected", out_data);
      end else begin
        want_rsp = expected_frames.pop_front();
        if (out_data.frame_valid !== want_rsp.frame_valid ||
            out_data.frame_kind !== want_rsp.frame_kind ||
            out_data.frame_alias !== want_rsp.frame_alias ||
            out_data.check_index !== want_rsp.check_index ||
            out_data.check_id_byte !== want_rsp.check_id_byte ||
            out_data.link_ready !== want_rsp.link_ready) begin
          errors++;
          if (errors <= 10) begin
            $display("tb: mismatch at %0t: exp valid=%0d kind=%0d alias=%h idx=%0d byte=%h rdy=%0d",
                     $realtime, want_rsp.frame_valid, want_rsp.frame_kind, want_rsp.frame_alias,
                     want_rsp.check_index, want_rsp.check_id_byte, want_rsp.link_ready);
            $display("tb:   got valid=%0d kind=%0d alias=%h idx=%0d byte=%h rdy=%0d",
                     out_data.frame_valid, out_data.frame_kind, out_data.frame_alias,
                     out_data.check_index, out_data.check_id_byte, out_data.link_ready);
          end
        end
      end
    end
  end

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_idle();
    if ($urandom_range(0, 3) != 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // response side: random stalls, plus a long hold-off on demand
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end else if (stall_left == 0 && !calm) begin
        stall_left = pick_idle();
      end
      if (stall_left != 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic caac_req_t make_req(input logic [1:0] rt, input logic [31:0] now,
                                         input logic tx, input logic [1:0] rk,
                                         input logic [11:0] ra, input logic [47:0] nid);
    caac_req_t r;
    r.req_type = rt;
    r.now_ms = now;
    r.tx_ready = tx;
    r.rx_kind = rk;
    r.rx_source_alias = ra;
    r.rx_node_id = nid;
    return r;
  endfunction

  task automatic send_request(input caac_req_t r);
    int unsigned gap;
    gap = calm ? 0 : pick_idle();
    if (gap != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = r;
    do @(posedge clk); while (!in_ready);
    expected_frames.push_back(advance_claim(r));
    sent++;
  endtask

  task automatic wait_for_responses();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [47:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_NODE_ID) m_node_id = value;
    else m_wait_ms = value[15:0];
  endtask

  task automatic test_before_start();
    send_request(make_req(REQ_POLL, 32'd0, 1'b1, RK_CHECK, 12'h000, 48'd0));
    send_request(make_req(REQ_RX, 32'd1, 1'b1, RK_CHECK, 12'h000, 48'd0));
    send_request(make_req(REQ_RX, 32'd2, 1'b0, RK_VERIFY, 12'h000, 48'd0));
    send_request(make_req(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, RK_OTHER, 12'hFFF, '1));
  endtask

  // full claim with zero wait; the wait straddles the 32-bit time wrap
  task automatic test_claim_sequence();
    wait_for_responses();
    write_reg(CFG_NODE_ID, 48'hFEDC_BA98_7601);
    write_reg(CFG_CONFIRM_WAIT, 48'd0);
    send_request(make_req(REQ_START, 32'd0, 1'b0, RK_CHECK, 12'h000, 48'd0));
    send_request(make_req(REQ_POLL, 32'd0, 1'b0, RK_CHECK, 12'h000, 48'd0));
    for (int i = 0; i < 6; i++)
      send_request(make_req(REQ_POLL, 32'd0, 1'b1, RK_CHECK, 12'h000, 48'd0));
    send_request(make_req(REQ_POLL, 32'hFFFF_FFFF, 1'b0, RK_CHECK, 12'h000, 48'd0));
    send_request(make_req(REQ_POLL, 32'hFFFF_FFFF, 1'b1, RK_CHECK, 12'h000, 48'd0));
    send_request(make_req(REQ_POLL, 32'd0, 1'b0, RK_CHECK, 12'h000, 48'd0));
    send_request(make_req(REQ_POLL, 32'd0, 1'b1, RK_CHECK, 12'h000, 48'd0));
    send_request(make_req(REQ_POLL, 32'd1, 1'b0, RK_CHECK, 12'h000, 48'd0));
    send_request(make_req(REQ_POLL, 32'd1, 1'b1, RK_CHECK, 12'h000, 48'd0));
    send_request(make_req(REQ_POLL, 32'd2, 1'b1, RK_CHECK, 12'h000, 48'd0));
  endtask

  task automatic test_rx_frames();
    send_request(make_req(REQ_RX, 32'd3, 1'b0, RK_CHECK, model_alias(), 48'd0));
    send_request(make_req(REQ_RX, 32'd4, 1'b0, RK_VERIFY, model_alias() ^ 12'h001, m_node_id));
    send_request(make_req(REQ_RX, 32'd5, 1'b1, RK_VERIFY, model_alias() ^ 12'h800,
                          m_node_id ^ 48'h1));
    send_request(make_req(REQ_RX, 32'd6, 1'b1, RK_RESERVE, model_alias(), 48'd0));
    send_request(make_req(REQ_RX, 32'd7, 1'b0, RK_VERIFY, model_alias(), m_node_id));
    send_request(make_req(REQ_RX, 32'd8, 1'b1, RK_OTHER, model_alias(), 48'd0));
    send_request(make_req(REQ_RX, 32'hFFFF_FFFF, 1'b1, RK_OTHER, 12'hFFF, '1));
  endtask

  // receiver holds off while requests keep coming, then the sender drains
  task automatic test_backpressure();
    wait_for_responses();
    calm = 1'b1;
    @(posedge clk);
    hold_req = 60;
    send_request(make_req(REQ_START, 32'd100, 1'b1, RK_CHECK, 12'h000, 48'd0));
    for (int i = 0; i < 12; i++)
      send_request(make_req(REQ_POLL, 32'd100 + 32'(i) * 32'd300, 1'b1, RK_OTHER, 12'h000,
                            48'd0));
    wait_for_responses();
    calm = 1'b0;
  endtask

  task automatic pick_settings();
    logic [47:0] nid;
    logic [15:0] wait_ms;
    case ($urandom_range(0, 5))
      0: nid = '0;
      1: nid = '1;
      default: nid = rand48();
    endcase
    case ($urandom_range(0, 5))
      0: wait_ms = 16'd0;
      1: wait_ms = 16'hFFFF;
      2: wait_ms = ConfirmWaitReset;
      default: wait_ms = 16'($urandom_range(1, 200));
    endcase
    write_reg(CFG_NODE_ID, nid);
    write_reg(CFG_CONFIRM_WAIT, {32'd0, wait_ms});
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n)
      send_request(make_req(2'($urandom), $urandom, 1'($urandom), 2'($urandom),
                            12'($urandom), rand48()));
  endtask

  // one claim attempt with random timing, busy transmitter and foreign frames
  task automatic run_claim();
    logic [31:0] clock_ms;
    int unsigned budget;
    int unsigned pick;
    caac_req_t   r;
    clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000) : $urandom;
    send_request(make_req(REQ_START, clock_ms, 1'($urandom), 2'($urandom), 12'($urandom),
                          rand48()));
    budget = $urandom_range(12, 30);
    for (int unsigned s = 0; s < budget; s++) begin
      r = make_req(REQ_POLL, clock_ms, $urandom_range(0, 4) != 0, 2'($urandom),
                   12'($urandom), rand48());
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        r.req_type = REQ_RX;
        r.rx_source_alias = model_alias();
      end else if (pick < 4) begin
        r.req_type = REQ_RX;
        if ($urandom_range(0, 1) != 0) begin
          r.rx_kind = RK_VERIFY;
          r.rx_node_id = m_node_id;
        end
      end else if (pick < 8 && m_phase == PH_WAITING) begin
        // right at the wait boundary or one past it
        r.now_ms = m_wait_start + {16'd0, m_wait_ms} + 32'($urandom_range(0, 1));
      end
      send_request(r);
      clock_ms += $urandom_range(0, m_wait_ms / 3 + 2);
    end
  endtask

  task automatic test_random_claims();
    int unsigned target;
    int unsigned nseq;
    target = sent + 600;
    nseq = 0;
    while (sent < target) begin
      if (nseq % 8 == 0) begin
        wait_for_responses();
        pick_settings();
      end
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 6));
      else run_claim();
      nseq++;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_NODE_ID;
    cfg_data = '0;
    errors = 0;
    sent = 0;
    cycles = 0;
    hold_req = 0;
    calm = 1'b0;
    m_node_id = '0;
    m_wait_ms = ConfirmWaitReset;
    m_gen_hi = '0;
    m_gen_lo = '0;
    m_phase = PH_NOT_STARTED;
    m_wait_start = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_before_start();
    test_claim_sequence();
    test_rx_frames();
    test_backpressure();
    test_random_claims();

    wait_for_responses();
    repeat (4) @(posedge clk);
    errors += expected_frames.size();
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/caac_pkg.sv
hw/rtl/can_alias_allocation_controller_unit.sv
test/tb.sv
